FILE: src/pds_pkg.sv
// Shared types, constants and helper functions for the PLL divider search block.
// Pulled in by every module of the block; depends on nothing else.
package pds_pkg;

	localparam int WORD_W    = 32;
	localparam int ACH_W     = 28;
	localparam int REF_W     = 25;            // a valid reference (at most 20 MHz) fits here
	localparam int PADDR_W   = 3;
	localparam int DIV_NUM_W = 31;            // ref * (mult + 4) stays below 2^31
	localparam int DIV_DEN_W = 3;             // predivider + 1 is 1..5
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
	localparam int CFG_DIV_W = 11;            // (prediv + 1) << rfd, up to 1024
	localparam int CFG_PRD_W = ACH_W + CFG_DIV_W;

	localparam logic [WORD_W-1:0] MASK_PREDIV = 32'h7000_0000;
	localparam logic [WORD_W-1:0] MASK_MFD    = 32'h0F80_0000;
	localparam logic [WORD_W-1:0] MASK_RFD    = 32'h0038_0000;
	localparam logic [WORD_W-1:0] BIT_LOLRE   = 32'h0002_0000;
	localparam logic [WORD_W-1:0] BIT_LOLIRQ  = 32'h0000_4000;
	localparam logic [WORD_W-1:0] MASK_DEPTH  = 32'h0000_0C00;
	localparam logic [WORD_W-1:0] MASK_LOL    = BIT_LOLRE | BIT_LOLIRQ;
	localparam logic [WORD_W-1:0] MASK_CLEAR  = MASK_PREDIV | MASK_MFD | MASK_RFD |
		MASK_LOL | MASK_DEPTH;

	localparam logic [WORD_W-1:0] PHASE_MIN_HZ = 32'd4000000;
	localparam logic [WORD_W-1:0] ICO_MIN_HZ   = 32'd48000000;
	localparam logic [WORD_W-1:0] SYS_MAX_HZ   = 32'd147000000;
	localparam logic [WORD_W-1:0] REF_MIN_HZ   = 32'd8000000;
	localparam logic [WORD_W-1:0] REF_MAX_HZ   = 32'd20000000;
	localparam logic [WORD_W-1:0] REF_RESET_HZ = REF_MIN_HZ;

	localparam logic [2:0] PREDIV_LAST = 3'd4;
	localparam logic [4:0] MULT_LAST   = 5'd31;
	localparam int         RDIV_LAST   = 6;

	// register index on the configuration port
	localparam logic REG_REFERENCE = 1'b0;

	// result status codes
	localparam logic [1:0] ST_NEW        = 2'd0;
	localparam logic [1:0] ST_CONFIGURED = 2'd1;
	localparam logic [1:0] ST_BAD        = 2'd2;
	localparam logic [1:0] ST_NONE       = 2'd3;

	typedef struct packed {
		logic       load;
		logic       cfg_mul;
		logic       init_search;
		logic       div_start;
		logic       eval;
		logic       next_m;
		logic       next_p;
		logic       emit;
		logic [1:0] emit_code;
	} pds_cmd_t;

	typedef struct packed {
		logic args_ok;
		logic cfg_match;
		logic phase_ok;
		logic p_last;
		logic m_last;
		logic div_done;
	} pds_stat_t;

	// lowest reference that keeps the phase clock at or above 4 MHz
	function automatic logic [REF_W-1:0] phase_limit(input logic [2:0] pd);
		logic [REF_W-1:0] lim;
		case (pd)
			3'd0:    lim = REF_W'(PHASE_MIN_HZ);
			3'd1:    lim = REF_W'(PHASE_MIN_HZ * 2);
			3'd2:    lim = REF_W'(PHASE_MIN_HZ * 3);
			3'd3:    lim = REF_W'(PHASE_MIN_HZ * 4);
			default: lim = REF_W'(PHASE_MIN_HZ * 5);
		endcase
		return lim;
	endfunction

	// base must already have the divider, depth and loss-of-lock fields cleared
	function automatic logic [WORD_W-1:0] build_word(input logic [WORD_W-1:0] base,
		input logic [2:0] pd, input logic [4:0] mf, input logic [2:0] rd);
		return base | {1'b0, pd, mf, 1'b0, rd, 19'd0};
	endfunction

endpackage

FILE: src/pds_divider.sv
// Restoring divider, one quotient bit per cycle, for the ICO frequency.
// Depends on pds_pkg for its widths.
module pds_divider import pds_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] dividend,
	input  logic [DIV_DEN_W-1:0] divisor,
	output logic [DIV_NUM_W-1:0] quotient,
	output logic                 done
);

	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 take;

	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (run_q) begin
			// shift the next dividend bit in, keep the quotient bit in its place
			rem_q <= take ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], take};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

FILE: src/pds_datapath.sv
// Datapath of the PLL divider search: argument checks, lock match, search
// counters, best-candidate tracking and result registers. Uses pds_pkg and pds_divider.
module pds_datapath import pds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WORD_W-1:0] ref_hz,
	input  logic [WORD_W-1:0] req_in,
	input  logic [WORD_W-1:0] cur_in,
	input  logic              locked_in,
	input  pds_cmd_t          cmd,
	output pds_stat_t         stat,
	output logic [1:0]        status,
	output logic [2:0]        prediv_code,
	output logic [4:0]        mult_code,
	output logic [2:0]        rdiv_code,
	output logic [ACH_W-1:0]  achieved_hz,
	output logic [WORD_W-1:0] transition_control,
	output logic [WORD_W-1:0] final_control
);

	logic [WORD_W-1:0]    req_q;
	logic [WORD_W-1:0]    cur_q;
	logic                 locked_q;
	logic [REF_W-1:0]     ref_v;

	logic [3:0]           cur_pd1;
	logic [5:0]           cur_mf4;
	logic [CFG_DIV_W-1:0] cfg_div;
	logic [DIV_NUM_W-1:0] n0_q;
	logic [CFG_PRD_W-1:0] dprod_q;
	logic [CFG_PRD_W-1:0] n0_ext;

	logic [2:0]           p_q;
	logic [4:0]           m_q;
	logic [5:0]           m4;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic [DIV_NUM_W-1:0] ico;
	logic                 div_done;
	logic                 ico_ok;
	logic [ACH_W-1:0]     ico28;
	logic                 hit;
	logic [2:0]           sel_r;
	logic [ACH_W-1:0]     cand;
	logic                 update;

	logic [ACH_W-1:0]     best_q;
	logic [2:0]           bp_q;
	logic [4:0]           bm_q;
	logic [2:0]           br_q;
	logic                 found_q;
	logic [WORD_W-1:0]    base;

	logic [1:0]           status_q;
	logic [2:0]           prediv_q;
	logic [4:0]           mult_q;
	logic [2:0]           rdiv_q;
	logic [ACH_W-1:0]     ach_q;
	logic [WORD_W-1:0]    trans_q;
	logic [WORD_W-1:0]    final_q;

	assign ref_v = ref_hz[REF_W-1:0];

	// argument checks
	assign stat.args_ok = (ref_hz >= REF_MIN_HZ) && (ref_hz <= REF_MAX_HZ) &&
		(req_q != '0) && (req_q <= SYS_MAX_HZ);

	// lock match: floor(N / D) == req  <=>  req*D <= N < req*D + D
	assign cur_pd1 = {1'b0, cur_q[30:28]} + 4'd1;
	assign cur_mf4 = {1'b0, cur_q[27:23]} + 6'd4;
	assign cfg_div = {{(CFG_DIV_W-4){1'b0}}, cur_pd1} << cur_q[21:19];
	assign n0_ext  = CFG_PRD_W'(n0_q);
	assign stat.cfg_match = locked_q && (n0_ext >= dprod_q) &&
		(n0_ext < dprod_q + CFG_PRD_W'(cfg_div));

	// search
	assign m4      = {1'b0, m_q} + 6'd4;
	assign div_num = DIV_NUM_W'(ref_v) * DIV_NUM_W'(m4);
	assign div_den = p_q + 3'd1;

	assign stat.phase_ok = ref_v >= phase_limit(p_q);
	assign stat.p_last   = p_q == PREDIV_LAST;
	assign stat.m_last   = m_q == MULT_LAST;
	assign stat.div_done = div_done;

	pds_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (ico),
		.done     (div_done)
	);

	assign ico_ok = (ico >= DIV_NUM_W'(ICO_MIN_HZ)) && (ico <= DIV_NUM_W'(SYS_MAX_HZ));
	assign ico28  = ico[ACH_W-1:0];

	// the smallest shift that brings the ICO clock to or under the target gives the largest candidate
	always_comb begin
		hit   = 1'b0;
		sel_r = '0;
		for (int r = RDIV_LAST; r >= 0; r--) begin
			if ((ico28 >> r) <= req_q[ACH_W-1:0]) begin
				hit   = 1'b1;
				sel_r = 3'(r);
			end
		end
	end

	assign cand   = ico28 >> sel_r;
	assign update = ico_ok && hit && (cand > best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q     <= '0;
			m_q     <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.init_search) begin
				p_q     <= '0;
				m_q     <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.eval && update)
					found_q <= 1'b1;
				if (cmd.next_p || (cmd.next_m && stat.m_last)) begin
					m_q <= '0;
					p_q <= p_q + 3'd1;
				end else if (cmd.next_m) begin
					m_q <= m_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req_in;
			cur_q    <= cur_in;
			locked_q <= locked_in;
		end
		if (cmd.cfg_mul) begin
			n0_q    <= DIV_NUM_W'(ref_v) * DIV_NUM_W'(cur_mf4);
			dprod_q <= CFG_PRD_W'(req_q[ACH_W-1:0]) * CFG_PRD_W'(cfg_div);
		end
		if (cmd.init_search) begin
			best_q <= '0;
			bp_q   <= '0;
			bm_q   <= '0;
			br_q   <= '0;
		end else if (cmd.eval && update) begin
			best_q <= cand;
			bp_q   <= p_q;
			bm_q   <= m_q;
			br_q   <= sel_r;
		end
	end

	assign base = cur_q & ~MASK_CLEAR;

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= cmd.emit_code;
			prediv_q <= '0;
			mult_q   <= '0;
			rdiv_q   <= '0;
			ach_q    <= '0;
			trans_q  <= '0;
			final_q  <= '0;
			case (cmd.emit_code)
				ST_BAD: begin
				end
				ST_CONFIGURED: begin
					ach_q   <= req_q[ACH_W-1:0];
					trans_q <= cur_q;
					final_q <= cur_q;
				end
				default: begin
					if (found_q) begin
						status_q <= ST_NEW;
						prediv_q <= bp_q;
						mult_q   <= bm_q;
						rdiv_q   <= br_q;
						ach_q    <= best_q;
						trans_q  <= build_word(base, bp_q, bm_q, br_q + 3'd1);
						final_q  <= build_word(base, bp_q, bm_q, br_q) | (cur_q & MASK_LOL);
					end else begin
						status_q <= ST_NONE;
					end
				end
			endcase
		end
	end

	assign status             = status_q;
	assign prediv_code        = prediv_q;
	assign mult_code          = mult_q;
	assign rdiv_code          = rdiv_q;
	assign achieved_hz        = ach_q;
	assign transition_control = trans_q;
	assign final_control      = final_q;

endmodule

FILE: src/pds_ctrl.sv
// Controller state machine of the PLL divider search: sequences the checks and
// the predivider/multiplier sweep. Uses pds_pkg for the command and status types.
module pds_ctrl import pds_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  pds_stat_t stat,
	output pds_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_CFG   = 3'd2;
	localparam logic [2:0] S_PHASE = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!stat.args_ok) begin
					cmd.emit      = 1'b1;
					cmd.emit_code = ST_BAD;
					state_d       = S_IDLE;
				end else begin
					cmd.cfg_mul = 1'b1;
					state_d     = S_CFG;
				end
			end
			S_CFG: begin
				if (stat.cfg_match) begin
					cmd.emit      = 1'b1;
					cmd.emit_code = ST_CONFIGURED;
					state_d       = S_IDLE;
				end else begin
					cmd.init_search = 1'b1;
					state_d         = S_PHASE;
				end
			end
			S_PHASE: begin
				// drop a predivider whose phase clock is too slow
				if (stat.phase_ok)
					state_d = S_MUL;
				else if (stat.p_last)
					state_d = S_FIN;
				else
					cmd.next_p = 1'b1;
			end
			S_MUL: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.eval   = 1'b1;
					cmd.next_m = 1'b1;
					if (stat.p_last && stat.m_last)
						state_d = S_FIN;
					else if (stat.m_last)
						state_d = S_PHASE;
					else
						state_d = S_MUL;
				end
			end
			S_FIN: begin
				cmd.emit      = 1'b1;
				cmd.emit_code = ST_NEW;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.emit;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

endmodule

FILE: src/pll_divider_search.sv
// Top level of the PLL divider search: reference clock register on the APB port,
// controller and datapath. Depends on pds_pkg, pds_ctrl, pds_datapath.
//
// Usage:
//  - Configuration: write the crystal reference (Hz) to address 0 over APB while
//    the block is idle. pready is always high; reads return the register. Reset
//    value is 8 MHz.
//  - Request: drive requested_hz, current_control and pll_locked and raise start;
//    the transaction is taken at an edge where start is high and busy is low.
//  - Result: done is high for exactly one cycle with status, the chosen codes,
//    achieved_hz and the transition and final control words. It cannot be held
//    off, so capture it in that cycle; busy is already low then.
//  - Sequence: bad arguments are reported straight from the check state, an
//    already configured PLL from the lock-match state, and otherwise a full
//    search runs. It visits every predivider whose phase clock is fast enough
//    and every multiplier code, using the one-bit-per-cycle divider (31 steps)
//    to compute each ICO clock. One transaction is in flight at a time.
//  - Reset: asynchronous, active low; drops any transaction in flight and
//    restores the reference register.
module pll_divider_search import pds_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [WORD_W-1:0]  pwdata,
	output logic [WORD_W-1:0]  prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [WORD_W-1:0]  requested_hz,
	input  logic [WORD_W-1:0]  current_control,
	input  logic               pll_locked,
	output logic               done,
	output logic [1:0]         status,
	output logic [2:0]         prediv_code,
	output logic [4:0]         mult_code,
	output logic [2:0]         rdiv_code,
	output logic [ACH_W-1:0]   achieved_hz,
	output logic [WORD_W-1:0]  transition_control,
	output logic [WORD_W-1:0]  final_control
);

	logic [WORD_W-1:0] ref_q;
	logic              reg_hit;
	pds_cmd_t          cmd;
	pds_stat_t         stat;

	assign reg_hit = paddr[PADDR_W-1] == REG_REFERENCE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ref_q <= REF_RESET_HZ;
		else if (psel && penable && pwrite && reg_hit)
			ref_q <= pwdata;
	end

	assign prdata = reg_hit ? ref_q : '0;
	assign pready = 1'b1;

	pds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pds_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.ref_hz             (ref_q),
		.req_in             (requested_hz),
		.cur_in             (current_control),
		.locked_in          (pll_locked),
		.cmd                (cmd),
		.stat               (stat),
		.status             (status),
		.prediv_code        (prediv_code),
		.mult_code          (mult_code),
		.rdiv_code          (rdiv_code),
		.achieved_hz        (achieved_hz),
		.transition_control (transition_control),
		.final_control      (final_control)
	);

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a transaction is still running");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted transaction did not occupy the block");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_BAD || status == ST_NONE) |->
		achieved_hz == '0 && transition_control == '0 && final_control == '0)
		else $error("rejected transaction carries a non-zero result");

	a_new_codes: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_NEW |->
		prediv_code <= PREDIV_LAST && rdiv_code <= 3'(RDIV_LAST) && achieved_hz != '0)
		else $error("new setting outside the searched range");
`endif

endmodule

FILE: bench/pll_divider_search_tb.sv
// Self-checking bench for pll_divider_search: drives requests and reference writes,
// predicts every result in a local search model and compares each done strobe.
// Depends on pds_pkg and the pll_divider_search top level.
`timescale 1ns / 100ps

module pll_divider_search_tb;
	import pds_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam logic [PADDR_W-1:0] REFERENCE_ADDR = PADDR_W'(4 * REG_REFERENCE);

	typedef struct packed {
		logic [1:0]        status;
		logic [2:0]        prediv;
		logic [4:0]        mult;
		logic [2:0]        rdiv;
		logic [ACH_W-1:0]  achieved;
		logic [WORD_W-1:0] transition_word;
		logic [WORD_W-1:0] final_word;
	} pll_setting_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [WORD_W-1:0]  pwdata = '0;
	logic [WORD_W-1:0]  prdata;
	logic               pready;
	logic               start = 1'b0;
	logic               busy;
	logic [WORD_W-1:0]  requested_hz = '0;
	logic [WORD_W-1:0]  current_control = '0;
	logic               pll_locked = 1'b0;
	logic               done;
	logic [1:0]         status;
	logic [2:0]         prediv_code;
	logic [4:0]         mult_code;
	logic [2:0]         rdiv_code;
	logic [ACH_W-1:0]   achieved_hz;
	logic [WORD_W-1:0]  transition_control;
	logic [WORD_W-1:0]  final_control;

	logic [WORD_W-1:0] reference_hz = REF_RESET_HZ;
	pll_setting_t      pending_settings[$];
	int                fail_count = 0;
	int                clk_cycles = 0;
	bit                steady_run = 1'b0;

	pll_divider_search dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.requested_hz(requested_hz), .current_control(current_control),
		.pll_locked(pll_locked),
		.done(done), .status(status), .prediv_code(prediv_code),
		.mult_code(mult_code), .rdiv_code(rdiv_code), .achieved_hz(achieved_hz),
		.transition_control(transition_control), .final_control(final_control)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		clk_cycles++;
		if (clk_cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// clock the present control word would give: ref * (MFD + 4) / ((PREDIV + 1) << RFD)
	function automatic logic [63:0] decoded_clock(input logic [31:0] ref_hz,
		input logic [31:0] word);
		return (64'(ref_hz) * (64'(word[27:23]) + 64'd4)) /
			((64'(word[30:28]) + 64'd1) << word[21:19]);
	endfunction

	function automatic pll_setting_t predict_pll_setting(input logic [31:0] ref_hz,
		input logic [31:0] req, input logic [31:0] cur, input logic locked);
		pll_setting_t res;
		logic [63:0]  ico;
		logic [31:0]  best;
		logic [31:0]  cand;
		logic [31:0]  base;
		bit           found;
		int           p;
		int           m;
		int           r;
		res = '0;
		best = '0;
		found = 1'b0;
		if (ref_hz < REF_MIN_HZ || ref_hz > REF_MAX_HZ || req == '0 || req > SYS_MAX_HZ) begin
			res.status = ST_BAD;
			return res;
		end
		if (locked && decoded_clock(ref_hz, cur) == 64'(req)) begin
			res.status = ST_CONFIGURED;
			res.achieved = req[ACH_W-1:0];
			res.transition_word = cur;
			res.final_word = cur;
			return res;
		end
		// predivider outermost; strict compare keeps the first hit on a tie
		for (p = 0; p <= 4; p++) begin
			if ((ref_hz / 32'(p + 1)) < PHASE_MIN_HZ)
				continue;
			for (m = 0; m <= 31; m++) begin
				ico = (64'(ref_hz) * 64'(m + 4)) / 64'(p + 1);
				if (ico < 64'(ICO_MIN_HZ) || ico > 64'(SYS_MAX_HZ))
					continue;
				for (r = 0; r <= 6; r++) begin
					cand = 32'(ico >> r);
					if (cand > req || cand <= best)
						continue;
					res.prediv = 3'(p);
					res.mult = 5'(m);
					res.rdiv = 3'(r);
					best = cand;
					found = 1'b1;
				end
			end
		end
		if (!found) begin
			res = '0;
			res.status = ST_NONE;
			return res;
		end
		res.status = ST_NEW;
		res.achieved = best[ACH_W-1:0];
		base = cur & ~MASK_CLEAR;
		base = base | (32'(res.prediv) << 28) | (32'(res.mult) << 23);
		res.transition_word = base | (32'(res.rdiv + 3'd1) << 19);
		res.final_word = base | (32'(res.rdiv) << 19) | (cur & (BIT_LOLRE | BIT_LOLIRQ));
		return res;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch on %s: expected %h, got %h", what, want, got);
	endtask

	// done cannot be held off: take every strobe at the edge that ends it
	always @(posedge clk) begin : check_results
		pll_setting_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_settings.size() == 0) begin
				note_mismatch("result with no transaction waiting", '0, 32'(status));
			end else begin
				want = pending_settings.pop_front();
				if (status !== want.status)
					note_mismatch("status", 32'(want.status), 32'(status));
				if (prediv_code !== want.prediv)
					note_mismatch("prediv_code", 32'(want.prediv), 32'(prediv_code));
				if (mult_code !== want.mult)
					note_mismatch("mult_code", 32'(want.mult), 32'(mult_code));
				if (rdiv_code !== want.rdiv)
					note_mismatch("rdiv_code", 32'(want.rdiv), 32'(rdiv_code));
				if (achieved_hz !== want.achieved)
					note_mismatch("achieved_hz", 32'(want.achieved), 32'(achieved_hz));
				if (transition_control !== want.transition_word)
					note_mismatch("transition_control", want.transition_word,
						transition_control);
				if (final_control !== want.final_word)
					note_mismatch("final_control", want.final_word, final_control);
			end
		end
	end

	task automatic send_request(input logic [31:0] req, input logic [31:0] cur,
		input logic locked);
		int gap;
		gap = steady_run ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		requested_hz <= req;
		current_control <= cur;
		pll_locked <= locked;
		do @(posedge clk); while (busy !== 1'b0);
		pending_settings.push_back(predict_pll_setting(reference_hz, req, cur, locked));
	endtask

	// hold start low until every transaction in flight has reported
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_settings.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_transfer(input logic is_write, input logic [31:0] wdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= REFERENCE_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (!is_write && prdata !== reference_hz)
			note_mismatch("prdata", reference_hz, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reference(input logic [31:0] value);
		drain_results();
		apb_transfer(1'b1, value);
		reference_hz = value;
		apb_transfer(1'b0, '0);
	endtask

	task automatic test_argument_limits();
		apb_transfer(1'b0, '0);
		send_request(32'd0, $urandom, 1'b1);
		send_request(32'd1, $urandom, 1'b0);
		send_request(32'd750000, $urandom, 1'b0);
		send_request(SYS_MAX_HZ, $urandom, 1'b0);
		send_request(SYS_MAX_HZ + 32'd1, $urandom, 1'b1);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_request(32'h8000_0000, '0, 1'b0);
	endtask

	task automatic test_already_configured();
		logic [31:0] word;
		word = $urandom;
		word[30:28] = 3'd0;
		word[27:23] = 5'd8;
		word[21:19] = 3'd1;
		send_request(32'(decoded_clock(reference_hz, word)), word, 1'b1);
		send_request(32'(decoded_clock(reference_hz, word)), word, 1'b0);
		send_request(32'(decoded_clock(reference_hz, word)) + 32'd1, word, 1'b1);
		// full three-bit predivider and divider fields count in the decode
		word[30:28] = 3'd7;
		word[27:23] = 5'd31;
		word[21:19] = 3'd7;
		send_request(32'(decoded_clock(reference_hz, word)), word, 1'b1);
		word[30:28] = 3'd5;
		word[27:23] = 5'd0;
		word[21:19] = 3'd6;
		send_request(32'(decoded_clock(reference_hz, word)), word, 1'b1);
	endtask

	task automatic test_control_word_fields();
		send_request(32'd100000000, '0, 1'b0);
		send_request(32'd100000000, 32'hFFFF_FFFF, 1'b0);
		send_request(32'd64000000, BIT_LOLRE | BIT_LOLIRQ, 1'b0);
		send_request(32'd33000000, ~MASK_CLEAR, 1'b1);
		send_request(32'(decoded_clock(reference_hz, 32'hFFFF_FFFF)), 32'hFFFF_FFFF, 1'b1);
	endtask

	task automatic test_reference_range();
		write_reference(REF_MAX_HZ);
		send_request(SYS_MAX_HZ, $urandom, 1'b0);
		send_request(32'd1000000, $urandom, 1'b0);
		send_request(32'd33333333, $urandom, 1'b1);
		write_reference(REF_MIN_HZ - 32'd1);
		send_request(32'd100000000, $urandom, 1'b0);
		write_reference(REF_MAX_HZ + 32'd1);
		send_request(32'd100000000, $urandom, 1'b0);
		write_reference('0);
		send_request(32'd48000000, $urandom, 1'b1);
		write_reference(32'hFFFF_FFFF);
		send_request(32'd48000000, $urandom, 1'b0);
		write_reference(32'd12000000);
		send_request(32'd120000000, $urandom, 1'b0);
		write_reference(REF_MIN_HZ);
		send_request(32'd80000000, $urandom, 1'b0);
	endtask

	task automatic test_random_requests();
		logic [31:0] req;
		logic [31:0] cur;
		logic [63:0] dec;
		logic        locked;
		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 3 && $urandom_range(0, 3) == 0)
				write_reference($urandom);
			else
				write_reference($urandom_range(REF_MAX_HZ, REF_MIN_HZ));
			for (int i = 0; i < 25; i++) begin
				if (i % 8 == 0)
					steady_run = ($urandom_range(0, 2) == 0);
				cur = $urandom;
				locked = 1'($urandom_range(0, 1));
				case ($urandom_range(0, 9))
					0: req = $urandom;
					1: req = SYS_MAX_HZ + 32'($urandom_range(0, 4)) - 32'd2;
					2: begin
						// steer toward a word that decodes to a legal request
						cur[30:28] = 3'($urandom_range(0, 4));
						cur[21:19] = 3'($urandom_range(0, 3));
						dec = decoded_clock(reference_hz, cur);
						locked = 1'b1;
						if (dec >= 64'd1 && dec <= 64'(SYS_MAX_HZ))
							req = dec[31:0];
						else
							req = $urandom_range(1, SYS_MAX_HZ);
					end
					3: req = $urandom_range(1, 2000000);
					default: req = $urandom_range(1, SYS_MAX_HZ);
				endcase
				send_request(req, cur, locked);
				if (phase == 1 && i == 12)
					drain_results();
			end
		end
		steady_run = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_argument_limits();
		test_already_configured();
		test_control_word_fields();
		test_reference_range();
		test_random_requests();
		drain_results();
		repeat (16) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
